>>> sv/ar3d_pkg.sv
`default_nettype none

package ar3d_pkg;

    localparam int COORD_W     = 32;
    localparam int ANGLE_W     = 32;
    localparam int STAGES      = 30;
    localparam int GUARD_SHIFT = 60 - COORD_W;
    localparam int ANG_SHIFT   = 56 - ANGLE_W;

    // Working vector: coordinates scaled to a 2^60 range plus CORDIC growth and sign
    localparam int VEC_W     = 63;
    // Working angle: pi is 2^55
    localparam int ANG_INT_W = 57;

    localparam int GAIN_W  = 63;
    localparam int SPLIT_W = 32;
    localparam int MH_W    = VEC_W - SPLIT_W;
    localparam int KH_W    = GAIN_W - SPLIT_W;
    localparam int PROD_W  = VEC_W + GAIN_W;
    localparam int HI_W    = PROD_W - 64;
    localparam int RND_W   = HI_W + 1 - (GUARD_SHIFT - 1);

    localparam int IN_DATA_W  = 3 * COORD_W + ANGLE_W;
    localparam int OUT_DATA_W = 3 * COORD_W;

    localparam logic [63:0] INV_PI_Q64 = 64'h517CC1B727220A95;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    typedef logic signed [VEC_W-1:0]     vec_t;
    typedef logic signed [ANG_INT_W-1:0] ang_t;

    typedef struct packed {
        logic [1:0]         op;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } side_t;

    localparam ang_t QUARTER_TURN = ang_t'(64'd1 << 54);
    localparam ang_t HALF_TURN    = ang_t'(64'd1 << 55);
    localparam ang_t NEG_QUARTER  = -QUARTER_TURN;

    // Elaboration-time helpers for the constant tables
    function automatic logic [63:0] mul_high64(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[127:64];
    endfunction

    function automatic logic [63:0] long_div(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], n[b]};
            if (rem >= d)
            begin
                rem  = rem - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [STAGES-1:0][ANG_INT_W-1:0] atan_table();
        logic [STAGES-1:0][ANG_INT_W-1:0] tab;
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] scaled;
        tab = '0;
        for (int i = 0; i < STAGES; i++)
        begin
            if (i == 0)
            begin
                tab[i] = ANG_INT_W'(64'd1 << 53);
            end
            else
            begin
                sum = '0;
                // arctangent series in Q.62 radians
                for (int k = 0; i * (2 * k + 1) <= 62; k++)
                begin
                    term = long_div(64'd1 << (62 - i * (2 * k + 1)), 64'(2 * k + 1));
                    if ((k & 1) != 0)
                        sum = sum - term;
                    else
                        sum = sum + term;
                end
                scaled = (mul_high64(sum, INV_PI_Q64) + 64'd64) >> 7;
                tab[i] = scaled[ANG_INT_W-1:0];
            end
        end
        return tab;
    endfunction

    function automatic logic [63:0] gain_q63();
        logic [63:0] p;
        logic [63:0] kval;
        logic [63:0] t;
        logic [63:0] sq;
        p = 64'd1 << 61;
        for (int i = 0; i < STAGES && i < 64; i++)
        begin
            if (2 * i < 64)
                p = p + (p >> (2 * i));
        end
        kval = '0;
        // keep the largest K with K*K*p at most one
        for (int b = 62; b >= 0; b--)
        begin
            t  = kval | (64'd1 << b);
            sq = mul_high64(t, t);
            if (mul_high64(sq, p) <= (64'd1 << 59))
                kval = t;
        end
        return kval;
    endfunction

    localparam logic [STAGES-1:0][ANG_INT_W-1:0] ATAN_TAB = atan_table();
    localparam logic [63:0]                      GAIN_RAW = gain_q63();
    localparam logic [GAIN_W-1:0]                GAIN_K   = GAIN_RAW[GAIN_W-1:0];

    function automatic vec_t widen_coord(input logic [COORD_W-1:0] c);
        return {{(VEC_W-COORD_W-GUARD_SHIFT){c[COORD_W-1]}}, c, {GUARD_SHIFT{1'b0}}};
    endfunction

    function automatic ang_t widen_angle(input logic [ANGLE_W-1:0] a);
        return {{(ANG_INT_W-ANGLE_W-ANG_SHIFT){a[ANGLE_W-1]}}, a, {ANG_SHIFT{1'b0}}};
    endfunction

endpackage

`default_nettype wire

>>> sv/ar3d_cordic.sv
`default_nettype none

module ar3d_cordic
    import ar3d_pkg::*;
(
    input  wire logic clk,
    input  wire logic ce,
    input  wire vec_t a_in,
    input  wire vec_t b_in,
    input  wire ang_t z_in,
    output vec_t      a_out,
    output vec_t      b_out
);

    vec_t a_reg [STAGES];
    vec_t b_reg [STAGES];
    ang_t z_reg [STAGES-1];

    for (genvar i = 0; i < STAGES; i++)
    begin : g_iter
        vec_t a_src;
        vec_t b_src;
        ang_t z_src;
        vec_t a_next;
        vec_t b_next;

        if (i == 0)
        begin : g_first
            assign a_src = a_in;
            assign b_src = b_in;
            assign z_src = z_in;
        end
        else
        begin : g_chain
            assign a_src = a_reg[i-1];
            assign b_src = b_reg[i-1];
            assign z_src = z_reg[i-1];
        end

        always_comb
        begin
            if (!z_src[ANG_INT_W-1])
            begin
                a_next = a_src - (b_src >>> i);
                b_next = b_src + (a_src >>> i);
            end
            else
            begin
                a_next = a_src + (b_src >>> i);
                b_next = b_src - (a_src >>> i);
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                a_reg[i] <= a_next;
                b_reg[i] <= b_next;
            end
        end

        // the residual angle after the last step is not needed
        if (i < STAGES - 1)
        begin : g_angle
            ang_t z_next;

            always_comb
            begin
                if (!z_src[ANG_INT_W-1])
                    z_next = z_src - ang_t'(ATAN_TAB[i]);
                else
                    z_next = z_src + ang_t'(ATAN_TAB[i]);
            end

            always_ff @(posedge clk)
            begin
                if (ce)
                    z_reg[i] <= z_next;
            end
        end
    end

    assign a_out = a_reg[STAGES-1];
    assign b_out = b_reg[STAGES-1];

endmodule

`default_nettype wire

>>> sv/ar3d_scale.sv
`default_nettype none

module ar3d_scale
    import ar3d_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               ce,
    input  wire vec_t               v_in,
    output logic [COORD_W-1:0]      result
);

    localparam logic [SPLIT_W-1:0] K_LO = GAIN_K[SPLIT_W-1:0];
    localparam logic [KH_W-1:0]    K_HI = GAIN_K[GAIN_W-1:SPLIT_W];
    localparam logic [RND_W-1:0]   LIM  = RND_W'(1) << (COORD_W - 1);
    localparam logic [RND_W-1:0]   LIM1 = LIM - RND_W'(1);
    localparam logic [HI_W:0]      HALF = (HI_W+1)'(1) << (GUARD_SHIFT - 2);

    // stage 1: magnitude
    logic             neg1_reg;
    logic [VEC_W-1:0] mag_reg;
    // stage 2: partial products
    logic                      neg2_reg;
    logic [2*SPLIT_W-1:0]      p_ll_reg;
    logic [SPLIT_W+KH_W-1:0]   p_lh_reg;
    logic [MH_W+SPLIT_W-1:0]   p_hl_reg;
    logic [MH_W+KH_W-1:0]      p_hh_reg;
    // stage 3: upper product word
    logic            neg3_reg;
    logic [HI_W-1:0] hi_reg;

    logic [PROD_W-1:0] prod_next;
    logic [HI_W:0]     rsum;
    logic [RND_W-1:0]  rnd;
    logic [RND_W-1:0]  rnd_neg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            neg1_reg <= v_in[VEC_W-1];
            mag_reg  <= v_in[VEC_W-1] ? VEC_W'(-v_in) : VEC_W'(v_in);

            neg2_reg <= neg1_reg;
            p_ll_reg <= (2*SPLIT_W)'(mag_reg[SPLIT_W-1:0]) * (2*SPLIT_W)'(K_LO);
            p_lh_reg <= (SPLIT_W+KH_W)'(mag_reg[SPLIT_W-1:0]) * (SPLIT_W+KH_W)'(K_HI);
            p_hl_reg <= (MH_W+SPLIT_W)'(mag_reg[VEC_W-1:SPLIT_W]) * (MH_W+SPLIT_W)'(K_LO);
            p_hh_reg <= (MH_W+KH_W)'(mag_reg[VEC_W-1:SPLIT_W]) * (MH_W+KH_W)'(K_HI);

            neg3_reg <= neg2_reg;
            hi_reg   <= prod_next[PROD_W-1:64];
        end
    end

    always_comb
    begin
        prod_next = PROD_W'(p_ll_reg)
                  + (PROD_W'(p_lh_reg) << SPLIT_W)
                  + (PROD_W'(p_hl_reg) << SPLIT_W)
                  + (PROD_W'(p_hh_reg) << (2 * SPLIT_W));
    end

    // round half away from zero on the magnitude, then saturate
    always_comb
    begin
        rsum    = {1'b0, hi_reg} + HALF;
        rnd     = rsum[HI_W:GUARD_SHIFT-1];
        rnd_neg = RND_W'(0) - rnd;
        if (neg3_reg)
        begin
            if (rnd > LIM)
                result = {1'b1, {(COORD_W-1){1'b0}}};
            else
                result = rnd_neg[COORD_W-1:0];
        end
        else
        begin
            if (rnd > LIM1)
                result = {1'b0, {(COORD_W-1){1'b1}}};
            else
                result = rnd[COORD_W-1:0];
        end
    end

endmodule

`default_nettype wire

>>> sv/axis_rotation_3d.sv
`default_nettype none

// Channel   Dir  Width  Contents
// s_axis    in   128    tdata: coord_x, coord_y, coord_z, angle; tuser: op
// m_axis    out  96     tdata: out_x, out_y, out_z
//
// One request per cycle while the pipeline is not held; each result passes through
// one fold stage, 30 micro-rotation stages, three gain multiply stages
// and the output register.
// Reset clears only the valid bits; the data path carries no reset.
// While a result sits in the output register untaken, the whole pipeline holds.

module axis_rotation_3d
    import ar3d_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [31:0] coord_x, [63:32] coord_y, [95:64] coord_z, [127:96] angle
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] op
    input  wire logic [1:0]            s_axis_tuser,

    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [31:0] out_x, [63:32] out_y, [95:64] out_z
    output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

    localparam int SIDE_DEPTH = STAGES + 4;

    logic ce;

    logic [COORD_W-1:0] in_x;
    logic [COORD_W-1:0] in_y;
    logic [COORD_W-1:0] in_z;
    logic [ANGLE_W-1:0] in_angle;

    vec_t a_sel;
    vec_t b_sel;
    ang_t z_sel;
    vec_t a0_next;
    vec_t b0_next;
    ang_t z0_next;
    vec_t a0_reg;
    vec_t b0_reg;
    ang_t z0_reg;

    side_t                 side_reg  [SIDE_DEPTH];
    logic [SIDE_DEPTH-1:0] valid_reg;

    vec_t               rot_a;
    vec_t               rot_b;
    logic [COORD_W-1:0] fin_a;
    logic [COORD_W-1:0] fin_b;

    side_t                   tail;
    logic [OUT_DATA_W-1:0]   out_next;
    logic                    out_valid_reg;
    logic [OUT_DATA_W-1:0]   out_data_reg;

    assign ce            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = ce;

    assign in_x     = s_axis_tdata[COORD_W-1:0];
    assign in_y     = s_axis_tdata[2*COORD_W-1:COORD_W];
    assign in_z     = s_axis_tdata[3*COORD_W-1:2*COORD_W];
    assign in_angle = s_axis_tdata[IN_DATA_W-1:3*COORD_W];

    // pick the pair that turns, then fold the angle into a quarter turn
    always_comb
    begin
        case (s_axis_tuser)
            AXIS_X:
            begin
                a_sel = widen_coord(in_y);
                b_sel = widen_coord(in_z);
            end
            AXIS_Y:
            begin
                a_sel = widen_coord(in_z);
                b_sel = widen_coord(in_x);
            end
            default:
            begin
                a_sel = widen_coord(in_x);
                b_sel = widen_coord(in_y);
            end
        endcase
        z_sel = widen_angle(in_angle);

        if (z_sel > QUARTER_TURN)
        begin
            z0_next = z_sel - HALF_TURN;
            a0_next = -a_sel;
            b0_next = -b_sel;
        end
        else if (z_sel < NEG_QUARTER)
        begin
            z0_next = z_sel + HALF_TURN;
            a0_next = -a_sel;
            b0_next = -b_sel;
        end
        else
        begin
            z0_next = z_sel;
            a0_next = a_sel;
            b0_next = b_sel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            a0_reg <= a0_next;
            b0_reg <= b0_next;
            z0_reg <= z0_next;
            side_reg[0] <= '{op: s_axis_tuser, x: in_x, y: in_y, z: in_z};
            for (int i = 1; i < SIDE_DEPTH; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            valid_reg     <= {valid_reg[SIDE_DEPTH-2:0], s_axis_tvalid};
            out_valid_reg <= valid_reg[SIDE_DEPTH-1];
        end
    end

    ar3d_cordic u_cordic
    (
        .clk   (clk),
        .ce    (ce),
        .a_in  (a0_reg),
        .b_in  (b0_reg),
        .z_in  (z0_reg),
        .a_out (rot_a),
        .b_out (rot_b)
    );

    ar3d_scale u_scale_a
    (
        .clk    (clk),
        .ce     (ce),
        .v_in   (rot_a),
        .result (fin_a)
    );

    ar3d_scale u_scale_b
    (
        .clk    (clk),
        .ce     (ce),
        .v_in   (rot_b),
        .result (fin_b)
    );

    // place the rotated pair back on its axes; the axis coordinate passes
    always_comb
    begin
        tail = side_reg[SIDE_DEPTH-1];
        case (tail.op)
            AXIS_X:  out_next = {fin_b, fin_a, tail.x};
            AXIS_Y:  out_next = {fin_a, tail.y, fin_b};
            AXIS_Z:  out_next = {tail.z, fin_b, fin_a};
            default: out_next = {tail.z, tail.y, tail.x};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ce)
            out_data_reg <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

>>> tb/axis_rotation_3d_test.sv
`timescale 1ns / 100ps

module axis_rotation_3d_test;
    import ar3d_pkg::*;

    localparam logic [1:0]         AXIS_NONE    = 2'd3;
    localparam logic [COORD_W-1:0] C_MAX        = 32'h7FFFFFFF;
    localparam logic [COORD_W-1:0] C_MIN        = 32'h80000000;
    localparam logic [ANGLE_W-1:0] ANG_EIGHTH   = 32'h20000000;
    localparam logic [ANGLE_W-1:0] ANG_QUARTER  = 32'h40000000;
    localparam logic [ANGLE_W-1:0] ANG_NEG_HALF = 32'h80000000;
    localparam logic [ANGLE_W-1:0] ANG_MAX      = 32'h7FFFFFFF;
    localparam int                 RAND_POINTS  = 650;

    // x in the lowest bits, as on m_axis_tdata
    typedef struct packed {
        logic [COORD_W-1:0] z;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } point_t;

    class rotation_predictor;
        longint      arctan[STAGES];
        logic [63:0] gain;
        point_t      expected_points[$];
        int          errors;

        function new();
            logic [63:0] sum;
            logic [63:0] term;
            logic [63:0] p;
            logic [63:0] t;
            logic [63:0] sq;
            errors    = 0;
            arctan[0] = 64'sd1 <<< 53;
            for (int i = 1; i < STAGES; i++)
            begin
                // atan(2^-i) in Q.62 radians, then scaled so pi is 2^55
                sum = '0;
                for (int k = 0; i * (2 * k + 1) <= 62; k++)
                begin
                    term = (64'd1 << (62 - i * (2 * k + 1))) / 64'(2 * k + 1);
                    sum  = (k % 2 != 0) ? sum - term : sum + term;
                end
                arctan[i] = longint'((mul_hi(sum, INV_PI_Q64) + 64'd64) >> 7);
            end
            p = 64'd1 << 61;
            for (int i = 0; i < STAGES; i++)
                p = p + (p >> (2 * i));
            // largest gain in Q0.63 whose square times p stays within one
            gain = '0;
            for (int b = 62; b >= 0; b--)
            begin
                t  = gain | (64'd1 << b);
                sq = mul_hi(t, t);
                if (mul_hi(sq, p) <= (64'd1 << 59))
                    gain = t;
            end
        endfunction

        function logic [63:0] mul_hi(input logic [63:0] a, input logic [63:0] b);
            logic [127:0] prod;
            prod = 128'(a) * 128'(b);
            return prod[127:64];
        endfunction

        function logic [COORD_W-1:0] scale_back(input longint v);
            logic [63:0] mag;
            logic [63:0] r;
            logic [63:0] lim;
            mag = (v < 0) ? 64'(-v) : 64'(v);
            r   = (mul_hi(mag, gain) + (64'd1 << (GUARD_SHIFT - 2))) >> (GUARD_SHIFT - 1);
            lim = 64'd1 << (COORD_W - 1);
            if (v < 0)
            begin
                if (r > lim)
                    r = lim;
                return COORD_W'(-r);
            end
            if (r > lim - 1)
                r = lim - 1;
            return COORD_W'(r);
        endfunction

        function void rotate(input longint a, input longint b, input longint ang,
                             output logic [COORD_W-1:0] ra, output logic [COORD_W-1:0] rb);
            longint da;
            longint db;
            // fold anything past a quarter turn by negating the vector
            if (ang > (64'sd1 <<< 54))
            begin
                ang = ang - (64'sd1 <<< 55);
                a   = -a;
                b   = -b;
            end
            else if (ang < -(64'sd1 <<< 54))
            begin
                ang = ang + (64'sd1 <<< 55);
                a   = -a;
                b   = -b;
            end
            for (int i = 0; i < STAGES; i++)
            begin
                da = b >>> i;
                db = a >>> i;
                if (ang >= 0)
                begin
                    a   = a - da;
                    b   = b + db;
                    ang = ang - arctan[i];
                end
                else
                begin
                    a   = a + da;
                    b   = b - db;
                    ang = ang + arctan[i];
                end
            end
            ra = scale_back(a);
            rb = scale_back(b);
        endfunction

        function void note_request(input logic [1:0] op, input logic [COORD_W-1:0] x,
                                   input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z,
                                   input logic [ANGLE_W-1:0] angle);
            point_t pt;
            longint wx;
            longint wy;
            longint wz;
            longint wa;
            wx   = longint'($signed(x)) <<< GUARD_SHIFT;
            wy   = longint'($signed(y)) <<< GUARD_SHIFT;
            wz   = longint'($signed(z)) <<< GUARD_SHIFT;
            wa   = longint'($signed(angle)) <<< ANG_SHIFT;
            pt.x = x;
            pt.y = y;
            pt.z = z;
            case (op)
                AXIS_X:  rotate(wy, wz, wa, pt.y, pt.z);
                AXIS_Y:  rotate(wz, wx, wa, pt.z, pt.x);
                AXIS_Z:  rotate(wx, wy, wa, pt.x, pt.y);
                default: ;
            endcase
            expected_points.push_back(pt);
        endfunction

        function void check_result(input logic [OUT_DATA_W-1:0] data);
            point_t got;
            point_t want;
            got = data;
            if (expected_points.size() == 0)
            begin
                $error("unexpected result %h with no request pending", data);
                errors++;
                return;
            end
            want = expected_points.pop_front();
            if (got.x !== want.x)
            begin
                $error("out_x mismatch: expected %h, actual %h", want.x, got.x);
                errors++;
            end
            if (got.y !== want.y)
            begin
                $error("out_y mismatch: expected %h, actual %h", want.y, got.y);
                errors++;
            end
            if (got.z !== want.z)
            begin
                $error("out_z mismatch: expected %h, actual %h", want.z, got.z);
                errors++;
            end
        endfunction

        function int pending();
            return expected_points.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [1:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    rotation_predictor sb;
    bit                steady = 0;

    axis_rotation_3d dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_request(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32],
                            s_axis_tdata[95:64], s_axis_tdata[127:96]);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // receiver: random stall bursts until the steady tail of the run
    initial
    begin
        m_axis_tready <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (!steady && $urandom_range(0, 9) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_point(input logic [1:0] op, input logic [COORD_W-1:0] x,
                              input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z,
                              input logic [ANGLE_W-1:0] angle);
        if (!steady && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {angle, z, y, x};
        s_axis_tuser  <= op;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic wait_drained();
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    function automatic logic [COORD_W-1:0] pick_coord();
        logic [31:0] r;
        r = $urandom();
        case ($urandom_range(0, 5))
            0:
            begin
                case ($urandom_range(0, 4))
                    0:       return C_MAX;
                    1:       return C_MIN;
                    2:       return '0;
                    3:       return 32'h1;
                    default: return 32'hFFFFFFFF;
                endcase
            end
            1:       return {{12{r[19]}}, r[19:0]};
            default: return r;
        endcase
    endfunction

    function automatic logic [ANGLE_W-1:0] pick_angle();
        logic [31:0] offset;
        offset = 32'($urandom_range(0, 64)) - 32'd32;
        case ($urandom_range(0, 7))
            0:       return ANG_QUARTER + offset;
            1:       return ANG_NEG_HALF + offset;
            2:       return -ANG_QUARTER + offset;
            3:       return offset;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [1:0] pick_axis();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return AXIS_NONE;
        case (r % 3)
            0:       return AXIS_X;
            1:       return AXIS_Y;
            default: return AXIS_Z;
        endcase
    endfunction

    initial
    begin
        sb = new();
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= AXIS_X;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // saturation, quarter and half turn folding, the unused selector
        send_point(AXIS_X, C_MAX, C_MAX, C_MAX, ANG_EIGHTH);
        send_point(AXIS_Y, C_MIN, C_MIN, C_MIN, ANG_EIGHTH);
        send_point(AXIS_Z, C_MIN, C_MIN, C_MIN, -ANG_EIGHTH);
        send_point(AXIS_Z, C_MAX, C_MIN, '0, ANG_MAX);
        send_point(AXIS_Z, 32'h20000000, '0, '0, ANG_NEG_HALF);
        send_point(AXIS_Z, C_MIN, C_MAX, 32'h1, ANG_QUARTER);
        send_point(AXIS_X, 32'h5, C_MIN, C_MIN, ANG_QUARTER + 32'd1);
        send_point(AXIS_Y, C_MAX, 32'h12345678, C_MIN, -ANG_QUARTER);
        send_point(AXIS_X, '0, C_MAX, 32'hFFFFFFFF, -ANG_QUARTER - 32'd1);
        send_point(AXIS_Z, 32'h20000000, 32'hE0000000, C_MAX, 32'h1);
        send_point(AXIS_Y, 32'hFFFFFFFF, '0, 32'h1, 32'hFFFFFFFF);
        send_point(AXIS_NONE, C_MAX, C_MIN, 32'hA5A5A5A5, ANG_EIGHTH);
        send_point(AXIS_NONE, C_MIN, C_MAX, '0, ANG_NEG_HALF);
        send_point(AXIS_X, '0, '0, '0, ANG_MAX);
        send_point(AXIS_Y, C_MIN, '0, C_MAX, ANG_NEG_HALF);
        send_point(AXIS_X, 32'h55555555, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA);
        send_point(AXIS_Z, 32'hAAAAAAAA, 32'h55555555, '0, 32'h55555555);

        for (int n = 0; n < RAND_POINTS; n++)
        begin
            // hold off once until the pipeline is empty
            if (n == RAND_POINTS / 2)
            begin
                s_axis_tvalid <= 1'b0;
                wait_drained();
            end
            if (n == RAND_POINTS - 100)
                steady = 1'b1;
            send_point(pick_axis(), pick_coord(), pick_coord(), pick_coord(), pick_angle());
        end
        s_axis_tvalid <= 1'b0;

        wait_drained();
        repeat (50) @(posedge clk);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
